[src/eeg_pkg.sv]
// Shared types for the extended Euclid GCD block: controller states and
// the command/status groups between controller and datapath. No dependencies.
`default_nettype none

package eeg_pkg;

    // Default operand width.
    localparam int EEG_WIDTH = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_DIVIDE,
        ST_UPDATE,
        ST_FINISH
    } eeg_state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;       // take a new operand pair
        logic div_start;  // clear divider, begin quotient of prev / cur
        logic div_step;   // one restoring-division bit
        logic update;     // advance remainder and coefficient pairs
        logic emit;       // copy result into output register
    } eeg_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic cur_zero;   // current remainder is zero: loop done
        logic out_free;   // output register can take a result this cycle
    } eeg_status_t;

endpackage

`default_nettype wire

[src/extended_euclid_gcd.sv]
// Extended Euclid GCD block, top level: stream ports, controller, datapath.
// Depends on eeg_pkg, eeg_ctrl and eeg_datapath.
//
// Usage
//   Input beat (s_ group): operand_a and operand_b, both unsigned. Output
//   beat (m_ group): divisor = gcd(a, b) and signed Bezout coefficients
//   coef_a, coef_b with a*coef_a + b*coef_b = divisor, the same pair the
//   recursive definition gives (a = 0 returns divisor b, coefs 0 and 1).
//   One output beat per input beat, in order.
// Timing
//   Each Euclid step runs a test state, the divide state of a shared
//   restoring divider that also accumulates q*x and q*y one quotient bit
//   at a time, and an update state. m_tvalid rises as the loop returns
//   to idle, where the next input beat can be taken. The loop runs at
//   most about 1.44*WIDTH steps (46 for 32-bit operands: a swap step plus
//   a 45-step Fibonacci chain). One item is in work at a time; s_tready
//   is high only while the loop is idle.
// Reset and stalls
//   aresetn (synchronous, active low) drops any item in work and empties
//   the output register. A finished result sits in the output register
//   while m_tready is low, and the next item is accepted meanwhile; a
//   second result waits in the loop until the register frees up.
`default_nettype none

module extended_euclid_gcd
    import eeg_pkg::*;
#(
    parameter int WIDTH = EEG_WIDTH
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // fields from bit 0: operand_a[WIDTH], operand_b[WIDTH], zero pad
    input  wire logic [((2*WIDTH+7)/8)*8-1:0]      s_tdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // fields from bit 0: divisor[WIDTH], coef_a[WIDTH+1], coef_b[WIDTH+1],
    // zero pad
    output logic [((3*WIDTH+2+7)/8)*8-1:0]         m_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready
);

    localparam int IN_TW  = ((2 * WIDTH + 7) / 8) * 8;
    localparam int OUT_TW = ((3 * WIDTH + 2 + 7) / 8) * 8;

    eeg_cmd_t         cmd;
    eeg_status_t      status;
    logic [WIDTH-1:0] divisor;
    logic [WIDTH:0]   coef_a, coef_b;

    eeg_ctrl #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    eeg_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .operand_a (s_tdata[WIDTH-1:0]),
        .operand_b (s_tdata[2*WIDTH-1:WIDTH]),
        .m_tready  (m_tready),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .divisor   (divisor),
        .coef_a    (coef_a),
        .coef_b    (coef_b)
    );

    // zero-extend into the byte-padded beat
    assign m_tdata = OUT_TW'({coef_b, coef_a, divisor});

`ifndef SYNTHESIS
    // results only leave the loop once the remainder has reached zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> status.cur_zero)
        else $error("result emitted before loop finished");

    // never overwrite a result that has not been taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_tvalid || m_tready))
        else $error("output register overwritten");

    // one item at a time: an accepted beat closes the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while loop busy");
`endif

endmodule

`default_nettype wire

[src/eeg_ctrl.sv]
// Controller for the extended Euclid GCD block: step sequencer and
// division bit counter. Depends on eeg_pkg.
`default_nettype none

module eeg_ctrl
    import eeg_pkg::*;
#(
    parameter int WIDTH = EEG_WIDTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire eeg_status_t status,
    output eeg_cmd_t         cmd
);

    localparam int CNT_W = $clog2(WIDTH);

    eeg_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             cnt_last;

    assign cnt_last = (cnt_reg == CNT_W'(WIDTH - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_TEST;
            end
            ST_TEST: begin
                cnt_next = '0;
                if (status.cur_zero) state_next = ST_FINISH;
                else                 state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last) state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                state_next = ST_TEST;
            end
            ST_FINISH: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        s_tready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_TEST: begin
                cmd.div_start = !status.cur_zero;
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
            end
            ST_FINISH: begin
                cmd.emit = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/eeg_datapath.sv]
// Datapath for the extended Euclid GCD block: remainder pair, coefficient
// pairs, bit-serial divider with quotient-times-coefficient accumulation,
// and the output register. Depends on eeg_pkg.
`default_nettype none

module eeg_datapath
    import eeg_pkg::*;
#(
    parameter int WIDTH = EEG_WIDTH
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire eeg_cmd_t       cmd,
    input  wire logic [WIDTH-1:0] operand_a,
    input  wire logic [WIDTH-1:0] operand_b,
    input  wire logic           m_tready,
    output eeg_status_t         status,
    output logic                m_tvalid,
    output logic [WIDTH-1:0]    divisor,
    output logic [WIDTH:0]      coef_a,
    output logic [WIDTH:0]      coef_b
);

    // remainders: prev = r[i-1], cur = r[i]; coefficients mod 2^(WIDTH+1)
    logic [WIDTH-1:0] rp_reg, rc_reg;
    logic [WIDTH:0]   sp_reg, sc_reg, tp_reg, tc_reg;
    // divider
    logic [WIDTH-1:0] num_reg, rem_reg;
    logic [WIDTH:0]   qs_reg, qt_reg;
    // output register
    logic             valid_reg, valid_next;
    logic [WIDTH-1:0] g_reg;
    logic [WIDTH:0]   x_reg, y_reg;

    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   trial_diff;
    logic             qbit;
    logic [WIDTH-1:0] rem_next;
    logic [WIDTH:0]   qs_next, qt_next;

    // one restoring-division bit; q*s and q*t built MSB first (Horner)
    assign trial      = {rem_reg, num_reg[WIDTH-1]};
    assign trial_diff = trial - {1'b0, rc_reg};
    assign qbit       = (trial >= {1'b0, rc_reg});
    assign rem_next   = qbit ? trial_diff[WIDTH-1:0] : trial[WIDTH-1:0];
    assign qs_next    = {qs_reg[WIDTH-1:0], 1'b0} + (qbit ? sc_reg : '0);
    assign qt_next    = {qt_reg[WIDTH-1:0], 1'b0} + (qbit ? tc_reg : '0);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rp_reg <= operand_b;
            rc_reg <= operand_a;
            sp_reg <= '0;
            sc_reg <= (WIDTH+1)'(1);
            tp_reg <= (WIDTH+1)'(1);
            tc_reg <= '0;
        end else if (cmd.update) begin
            rp_reg <= rc_reg;
            rc_reg <= rem_reg;
            sp_reg <= sc_reg;
            sc_reg <= sp_reg - qs_reg;
            tp_reg <= tc_reg;
            tc_reg <= tp_reg - qt_reg;
        end

        if (cmd.div_start) begin
            num_reg <= rp_reg;
            rem_reg <= '0;
            qs_reg  <= '0;
            qt_reg  <= '0;
        end else if (cmd.div_step) begin
            num_reg <= {num_reg[WIDTH-2:0], 1'b0};
            rem_reg <= rem_next;
            qs_reg  <= qs_next;
            qt_reg  <= qt_next;
        end

        if (cmd.emit) begin
            g_reg <= rp_reg;
            x_reg <= sp_reg;
            y_reg <= tp_reg;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (cmd.emit)      valid_next = 1'b1;
        else if (m_tready) valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) valid_reg <= 1'b0;
        else          valid_reg <= valid_next;
    end

    assign status.cur_zero = (rc_reg == '0);
    assign status.out_free = !valid_reg || m_tready;

    assign m_tvalid = valid_reg;
    assign divisor  = g_reg;
    assign coef_a   = x_reg;
    assign coef_b   = y_reg;

endmodule

`default_nettype wire
